### rtl/grmm_pkg.sv
// Shared constants and types for the grid range min/max tree unit.
`default_nettype none
package grmm_pkg;
  localparam int GridSize = 512;
  localparam int RowW = $clog2(GridSize);
  localparam int NodeW = $clog2(2 * GridSize);
  localparam int AddrW = RowW + NodeW;
  localparam int CoordW = 10;
  localparam int ValW = 31;
  localparam int SizeW = 10;
  localparam logic signed [ValW-1:0] BigPos = 31'sd1000000000;
  localparam logic signed [ValW-1:0] BigNeg = -31'sd1000000000;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic [1:0] REG_SIZE_IN_USE = 2'd0;

  typedef struct packed {
    logic load;
    logic wr_leaf;
    logic wr_up;
    logic rd_up;
    logic row_start;
    logic row_next;
    logic q_step;
    logic out_load;
  } grmm_cmd_t;

  typedef struct packed {
    logic wr_skip;
    logic up_done;
    logic q_empty;
    logic row_last;
    logic walk_done;
  } grmm_sts_t;
endpackage
`default_nettype wire

### rtl/grmm_datapath.sv
// Tree memory, address walk and min/max accumulators.
`default_nettype none
module grmm_datapath import grmm_pkg::*; (
  input  wire logic clk,
  input  wire grmm_cmd_t cmd,
  input  wire logic [SizeW-1:0] size_in_use,
  input  wire logic [CoordW-1:0] row_low,
  input  wire logic [CoordW-1:0] col_low,
  input  wire logic [CoordW-1:0] row_high,
  input  wire logic [CoordW-1:0] col_high,
  input  wire logic signed [ValW-1:0] value,
  output grmm_sts_t sts,
  output logic signed [ValW-1:0] min_value,
  output logic signed [ValW-1:0] max_value
);
  logic [63:0] mem [0:GridSize*2*GridSize-1];
  logic [63:0] rd_q;
  logic [SizeW:0] n;
  logic [CoordW:0] rlo_c, rhi_c, clo_c, chi_c;
  logic [RowW-1:0] row_r, row_nxt, rend_r;
  logic [NodeW:0] lo_r, hi_r, lo_nxt, hi_nxt, clo0_r, chi0_r;
  logic [NodeW-1:0] p_r, p_nxt;
  logic signed [ValW-1:0] mn_r, mx_r, wv_r, vsat, omin_r, omax_r;
  logic signed [ValW-1:0] mn_nxt, mx_nxt, a_mn, a_mx;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [63:0] wr_data;
  logic we, rd_en;
  logic signed [ValW-1:0] cmin, cmax;
  logic [63:0] left_r;
  logic up_phase_r;

  assign n = (size_in_use > SizeW'(GridSize)) ? (SizeW+1)'(GridSize) : {1'b0, size_in_use};
  assign rlo_c = (row_low == '0) ? (CoordW+1)'(1) : {1'b0, row_low};
  assign clo_c = (col_low == '0) ? (CoordW+1)'(1) : {1'b0, col_low};
  assign rhi_c = ({1'b0, row_high} > n) ? n : {1'b0, row_high};
  assign chi_c = ({1'b0, col_high} > n) ? n : {1'b0, col_high};
  assign vsat = (value > BigPos) ? BigPos : (value < BigNeg) ? BigNeg : value;

  // write: leaf, then per level read left/right children (two reads) and write parent
  always_comb begin
    rd_en = 1'b0;
    rd_addr = {row_r, p_r};
    we = 1'b0;
    wr_addr = {row_r, p_r};
    wr_data = '0;
    p_nxt = p_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.wr_leaf) begin
      we = 1'b1;
      wr_data = {{1{wv_r[ValW-1]}}, wv_r, {1{wv_r[ValW-1]}}, wv_r};
    end
    if (cmd.rd_up) begin
      rd_en = 1'b1;
      rd_addr = {row_r, p_r[NodeW-1:1], up_phase_r};
    end
    if (cmd.wr_up) begin
      we = 1'b1;
      wr_addr = {row_r, 1'b0, p_r[NodeW-1:1]};
      cmin = ($signed(left_r[30:0]) < $signed(rd_q[30:0])) ? left_r[30:0] : rd_q[30:0];
      cmax = ($signed(left_r[62:32]) > $signed(rd_q[62:32])) ? left_r[62:32] : rd_q[62:32];
      wr_data = {cmax[ValW-1], cmax, cmin[ValW-1], cmin};
      p_nxt = {1'b0, p_r[NodeW-1:1]};
    end else begin
      cmin = '0;
      cmax = '0;
    end
    if (cmd.q_step) begin
      rd_en = 1'b1;
      if (lo_r[0]) begin
        rd_addr = {row_r, lo_r[NodeW-1:0]};
        lo_nxt = lo_r + 1'b1;
      end else if (hi_r[0]) begin
        rd_addr = {row_r, hi_r[NodeW-1:0] - 1'b1};
        hi_nxt = hi_r - 1'b1;
      end else begin
        rd_en = 1'b0;
        lo_nxt = lo_r >> 1;
        hi_nxt = hi_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  logic acc_r;
  assign a_mn = $signed(rd_q[30:0]);
  assign a_mx = $signed(rd_q[62:32]);
  always_comb begin
    mn_nxt = mn_r;
    mx_nxt = mx_r;
    if (acc_r) begin
      if (a_mn < mn_r) mn_nxt = a_mn;
      if (a_mx > mx_r) mx_nxt = a_mx;
    end
  end

  assign row_nxt = row_r + 1'b1;
  always_ff @(posedge clk) begin
    acc_r <= cmd.q_step && rd_en;
    if (cmd.load) begin
      wv_r <= vsat;
      p_r <= NodeW'(GridSize) + NodeW'(col_low - 1'b1);
      rend_r <= RowW'(rhi_c - 1'b1);
      clo0_r <= (NodeW+1)'(GridSize) + (NodeW+1)'(clo_c - 1'b1);
      chi0_r <= (NodeW+1)'(GridSize) + (NodeW+1)'(chi_c);
      mn_r <= BigPos;
      mx_r <= BigNeg;
      up_phase_r <= 1'b0;
      if (row_low != '0) row_r <= RowW'(rlo_c - 1'b1);
      else row_r <= '0;
    end else begin
      mn_r <= mn_nxt;
      mx_r <= mx_nxt;
    end
    if (cmd.rd_up) begin
      up_phase_r <= ~up_phase_r;
    end
    if (cmd.wr_up || cmd.rd_up) p_r <= p_nxt;
    if (cmd.row_start) begin
      lo_r <= clo0_r;
      hi_r <= chi0_r;
    end else if (cmd.q_step) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (cmd.row_next) row_r <= row_nxt;
    if (cmd.out_load) begin
      omin_r <= mn_nxt;
      omax_r <= mx_nxt;
    end
  end

  // left child captured in the cycle after its read
  logic cap_left_r;
  always_ff @(posedge clk) begin
    cap_left_r <= cmd.rd_up && !up_phase_r;
    if (cap_left_r) left_r <= rd_q;
  end

  assign sts.wr_skip = (row_low == '0) || ({1'b0, row_low} > n) ||
                       (col_low == '0) || ({1'b0, col_low} > n);
  assign sts.up_done = (p_r[NodeW-1:1] == (NodeW-1)'(1));
  assign sts.q_empty = (rlo_c > rhi_c) || (clo_c > chi_c);
  assign sts.row_last = (row_r == rend_r);
  assign sts.walk_done = !(lo_r < hi_r);
  assign min_value = omin_r;
  assign max_value = omax_r;
endmodule
`default_nettype wire

### rtl/grmm_ctrl.sv
// Sequencer for write path refresh and query row walk.
`default_nettype none
module grmm_ctrl import grmm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic opcode,
  input  wire grmm_sts_t sts,
  input  wire logic out_ready,
  output grmm_cmd_t cmd,
  output logic in_ready,
  output logic out_valid
);
  localparam logic [3:0] S_IDLE = 4'd0, S_LEAF = 4'd1, S_RDL = 4'd2, S_RDR = 4'd3,
    S_WAIT = 4'd4, S_WUP = 4'd5, S_ROW = 4'd6, S_WALK = 4'd7, S_DRAIN = 4'd8,
    S_DRAIN2 = 4'd9, S_OUT = 4'd10, S_DEC = 4'd11;
  logic [3:0] st_r, st_nxt;
  logic ov_r, ov_nxt, op_r;

  always_comb begin
    st_nxt = st_r;
    ov_nxt = ov_r;
    cmd = '0;
    if (out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_fire) begin
        st_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.load = 1'b1;
        if (op_r == OP_WRITE) st_nxt = sts.wr_skip ? S_IDLE : S_LEAF;
        else st_nxt = sts.q_empty ? S_OUT : S_ROW;
      end
      S_LEAF: begin
        cmd.wr_leaf = 1'b1;
        st_nxt = sts.up_done ? S_IDLE : S_RDL;
      end
      S_RDL: begin
        cmd.rd_up = 1'b1;
        st_nxt = S_RDR;
      end
      S_RDR: begin
        cmd.rd_up = 1'b1;
        st_nxt = S_WAIT;
      end
      S_WAIT: st_nxt = S_WUP;
      S_WUP: begin
        cmd.wr_up = 1'b1;
        st_nxt = sts.up_done ? S_IDLE : S_RDL;
      end
      S_ROW: begin
        cmd.row_start = 1'b1;
        st_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_done) st_nxt = S_DRAIN;
        else cmd.q_step = 1'b1;
      end
      S_DRAIN: st_nxt = S_DRAIN2;
      S_DRAIN2: begin
        if (sts.row_last) st_nxt = S_OUT;
        else begin
          cmd.row_next = 1'b1;
          st_nxt = S_ROW;
        end
      end
      S_OUT: if (!ov_r || out_ready) begin
        cmd.out_load = 1'b1;
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    if (in_fire) op_r <= opcode;
  end

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
endmodule
`default_nettype wire

### rtl/grid_range_min_max_tree_unit.sv
// Top level of the grid range min/max tree unit.
// One transaction at a time. A write stores the leaf, then refreshes each level in
// read-left, read-right, wait and write-parent states, as the tree memory has one read
// port. A query walks each row, one tree node read or one level step per cycle.
// No clearing pass: every cell must be written before a query reads it.
`default_nettype none
module grid_range_min_max_tree_unit import grmm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic in_opcode,
  input  wire logic [CoordW-1:0] in_row_low,
  input  wire logic [CoordW-1:0] in_col_low,
  input  wire logic [CoordW-1:0] in_row_high,
  input  wire logic [CoordW-1:0] in_col_high,
  input  wire logic signed [ValW-1:0] in_value,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [ValW-1:0] out_min_value,
  output logic signed [ValW-1:0] out_max_value,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic [SizeW-1:0] size_r;
  grmm_cmd_t cmd;
  grmm_sts_t sts;
  logic in_fire;
  logic [CoordW-1:0] rl_r, cl_r, rh_r, ch_r;
  logic signed [ValW-1:0] v_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_SIZE_IN_USE) ? {22'd0, size_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= SizeW'(512);
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_SIZE_IN_USE)
      size_r <= cfg_pwdata[SizeW-1:0];
  end

  assign in_fire = in_valid && in_ready;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rl_r <= in_row_low;
      cl_r <= in_col_low;
      rh_r <= in_row_high;
      ch_r <= in_col_high;
      v_r <= in_value;
    end
  end

  grmm_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .opcode(in_opcode), .sts, .out_ready,
    .cmd, .in_ready, .out_valid
  );

  grmm_datapath u_dp (
    .clk, .cmd, .size_in_use(size_r), .row_low(rl_r), .col_low(cl_r),
    .row_high(rh_r), .col_high(ch_r), .value(v_r), .sts,
    .min_value(out_min_value), .max_value(out_max_value)
  );

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_value <= BigPos && out_max_value >= BigNeg)
    else $error("result out of range");
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(in_ready && cmd.out_load))
    else $error("result overwritten");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(cmd.q_step || cmd.wr_up))
    else $error("load during work");
endmodule
`default_nettype wire
